>>> src/ssm_pkg.sv
// Shared types, status codes and size constants of the sparse-set slot map.
// Depends on nothing; sparse_set_slot_map and its testbench import it.
package ssm_pkg;

  localparam int ID_W        = 10;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 8;
  localparam int OCC_OUT_W   = 9;
  localparam int CMP_W       = 17;

  localparam int DEF_MAX_ENTITIES = 1024;
  localparam int DEF_CAPACITY     = 256;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   entity_id;
    logic              has_animations;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  moved;
    logic [ID_W-1:0]       moved_entity;
    logic [OCC_OUT_W-1:0]  occupancy;
  } rsp_t;

endpackage

>>> src/ssm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sparse_set_slot_map.sv
// Sparse-set slot map: maps entity ids to packed dense slots, with
// swap-with-last removal. After reset the block sweeps the id map, one entry
// per cycle (MAX_ENTITIES entries, at most 1024), marking every entity
// absent, with req_ready low. After that it works on one beat at a time: the
// beat is taken in the idle cycle, where the id map and the slot list are
// read together; in the next cycle the answer is decided and the writes go
// out; a remove that moves the last entity takes a further move step for
// the second id-map write, which shares the id map's single write port; the
// result then enters the output register. A result waiting in the output
// register holds the block in its final step until rsp_ready takes it.
// Every request gives exactly one response. Status codes: added, already
// present, refused (no animations), full, removed, absent, found. On a remove
// with moved set, the entity in moved_entity now lives in the freed slot, so
// an outside payload store should copy its last slot into that slot.
// Depends on ssm_pkg and ssm_ram.
module sparse_set_slot_map #(
  parameter int MAX_ENTITIES = ssm_pkg::DEF_MAX_ENTITIES,
  parameter int CAPACITY     = ssm_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ssm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ssm_pkg::rsp_t rsp
);

  import ssm_pkg::*;

  // Id-map depth: ids are ID_W bits wide, so never more than 2**ID_W entries.
  localparam int IdDepth = (MAX_ENTITIES < (1 << ID_W)) ? MAX_ENTITIES : (1 << ID_W);
  localparam int IdAW    = $clog2(IdDepth);
  localparam int SlotW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CountW  = $clog2(CAPACITY + 1);
  localparam int MapW    = SlotW + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_MOVE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [IdAW-1:0]   clr_idx;
  logic [CountW-1:0] count;
  req_t              cur;
  rsp_t              res;

  // Memory ports.
  logic              map_we;
  logic [IdAW-1:0]   map_waddr;
  logic [MapW-1:0]   map_wdata;
  logic [IdAW-1:0]   map_raddr;
  logic [MapW-1:0]   map_rdata;
  logic              list_we;
  logic [SlotW-1:0]  list_waddr;
  logic [ID_W-1:0]   list_wdata;
  logic [SlotW-1:0]  list_raddr;
  logic [ID_W-1:0]   list_rdata;

  // Decision signals for the look cycle.
  logic                 hit;
  logic [SlotW-1:0]     hit_slot;
  logic                 in_range;
  logic                 last_in_range;
  logic [CountW-1:0]    last;
  logic                 will_move;
  logic [CountW-1:0]    count_next;
  logic [SlotW+SLOT_OUT_W-1:0] slot_ext;
  logic [CountW+OCC_OUT_W-1:0] occ_ext;
  rsp_t                 res_next;
  logic [2:0]           state_next;

  ssm_ram #(
    .WIDTH (MapW),
    .DEPTH (IdDepth),
    .AW    (IdAW)
  ) u_id_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  ssm_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY),
    .AW    (SlotW)
  ) u_slot_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  assign req_ready = (state == S_IDLE);

  // Read addresses are only meaningful in the accept cycle; the data arrives
  // in the look cycle. last wraps when the table is empty, but then the slot
  // list data is never used.
  assign last       = count - CountW'(1);
  assign map_raddr  = req.entity_id[IdAW-1:0];
  assign list_raddr = last[SlotW-1:0];

  assign in_range      = (CMP_W'(cur.entity_id) < CMP_W'(MAX_ENTITIES));
  assign last_in_range = (CMP_W'(list_rdata) < CMP_W'(MAX_ENTITIES));
  assign hit           = in_range && map_rdata[MapW-1];
  assign hit_slot      = map_rdata[SlotW-1:0];
  assign will_move     = (CountW'(hit_slot) != last) && last_in_range;

  always_comb begin
    map_we     = 1'b0;
    map_waddr  = cur.entity_id[IdAW-1:0];
    map_wdata  = '0;
    list_we    = 1'b0;
    list_waddr = hit_slot;
    list_wdata = list_rdata;
    count_next = count;
    state_next = state;
    res_next   = '0;
    slot_ext   = '0;

    case (state)
      S_CLEAR: begin
        // Sweep the id map to absent, one entry a cycle.
        map_we    = 1'b1;
        map_waddr = clr_idx;
        if (clr_idx == IdAW'(IdDepth - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_DONE;
        if (cur.kind == KIND_ADD) begin
          if (!cur.has_animations) begin
            res_next.status = ST_REFUSED;
          end else if (!in_range) begin
            res_next.status = ST_FULL;
          end else if (hit) begin
            res_next.status = ST_PRESENT;
            slot_ext        = (SlotW+SLOT_OUT_W)'(hit_slot);
          end else if (count >= CountW'(CAPACITY)) begin
            res_next.status = ST_FULL;
          end else begin
            // Append at the slot given by the count.
            map_we          = 1'b1;
            map_wdata       = {1'b1, count[SlotW-1:0]};
            list_we         = 1'b1;
            list_waddr      = count[SlotW-1:0];
            list_wdata      = cur.entity_id;
            count_next      = count + CountW'(1);
            res_next.status = ST_ADDED;
            slot_ext        = (SlotW+SLOT_OUT_W)'(count[SlotW-1:0]);
          end
        end else if (cur.kind == KIND_REMOVE) begin
          if (!hit || (count == '0)) begin
            res_next.status = ST_ABSENT;
          end else begin
            res_next.status = ST_REMOVED;
            slot_ext        = (SlotW+SLOT_OUT_W)'(hit_slot);
            count_next      = last;
            map_we          = 1'b1;
            if (will_move) begin
              // Point the last entity at the freed slot; clear the removed id
              // in the next cycle, as the id map has a single write port.
              map_waddr             = list_rdata[IdAW-1:0];
              map_wdata             = {1'b1, hit_slot};
              list_we               = 1'b1;
              res_next.moved        = 1'b1;
              res_next.moved_entity = list_rdata;
              state_next            = S_MOVE;
            end
          end
        end else begin
          if (hit) begin
            res_next.status = ST_FOUND;
            slot_ext        = (SlotW+SLOT_OUT_W)'(hit_slot);
          end else begin
            res_next.status = ST_ABSENT;
          end
        end
        res_next.slot = slot_ext[SLOT_OUT_W-1:0];
      end
      S_MOVE: begin
        map_we     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    occ_ext            = (CountW+OCC_OUT_W)'(count_next);
    res_next.occupancy = occ_ext[OCC_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + IdAW'(1);
      end
      // Drop the output beat once taken; load a new one from the done step.
      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      cur <= req;
    end
    if (state == S_LOOK) begin
      res <= res_next;
    end
    if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
      rsp <= res;
    end
  end

endmodule

>>> verif/sparse_set_slot_map_tb.sv
// Self-checking testbench for sparse_set_slot_map: directed and random add, remove and
// lookup beats, each predicted by a slot-map model in the scoreboard class below.
// Depends on ssm_pkg and the sparse_set_slot_map RTL only.
module sparse_set_slot_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;

  // The package names add and remove only; kind 2 is a lookup, and the spare
  // kind 3 must behave as one.
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
  localparam int N_IDS   = DEF_MAX_ENTITIES;
  localparam int N_SLOTS = DEF_CAPACITY;

  // Scoreboard: mirrors the id map, the dense slot list and the count, and
  // queues one expected response per accepted request beat.
  class slot_map_scoreboard;
    bit                  present[N_IDS];
    bit [SLOT_OUT_W-1:0] slot_of[N_IDS];
    bit [ID_W-1:0]       id_at[N_SLOTS];
    int unsigned         occupied;
    int unsigned         peak_occupied;
    rsp_t                expected_rsp[$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         moves_seen;
    int unsigned         status_seen[7];

    function new();
      occupied      = 0;
      peak_occupied = 0;
      errors        = 0;
      checked       = 0;
      moves_seen    = 0;
      foreach (present[i]) present[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Pick an entity currently in the set, or any entity if the set is empty.
    function logic [ID_W-1:0] pick_member();
      if (occupied == 0) return ID_W'($urandom_range(0, N_IDS - 1));
      return id_at[$urandom_range(0, occupied - 1)];
    endfunction

    // Advance the model by one accepted request and queue its response.
    function void note_request(req_t r);
      rsp_t                e;
      int unsigned         id;
      int unsigned         last;
      bit [ID_W-1:0]       last_id;
      e  = '0;
      id = 32'(r.entity_id);
      if (r.kind == KIND_ADD) begin
        if (!r.has_animations) begin
          e.status = ST_REFUSED;
        end else if (present[id]) begin
          e.status = ST_PRESENT;
          e.slot   = slot_of[id];
        end else if (occupied >= N_SLOTS) begin
          e.status = ST_FULL;
        end else begin
          id_at[occupied] = r.entity_id;
          slot_of[id]     = SLOT_OUT_W'(occupied);
          present[id]     = 1'b1;
          e.status        = ST_ADDED;
          e.slot          = SLOT_OUT_W'(occupied);
          occupied++;
        end
      end else if (r.kind == KIND_REMOVE) begin
        if (!present[id] || occupied == 0) begin
          e.status = ST_ABSENT;
        end else begin
          last     = occupied - 1;
          last_id  = id_at[last];
          e.status = ST_REMOVED;
          e.slot   = slot_of[id];
          // Swap-with-last: the last entity fills the hole unless it is the hole.
          if (slot_of[id] != last) begin
            id_at[slot_of[id]] = last_id;
            slot_of[last_id]   = slot_of[id];
            e.moved            = 1'b1;
            e.moved_entity     = last_id;
          end
          present[id] = 1'b0;
          slot_of[id] = '0;
          occupied    = last;
        end
      end else begin
        if (present[id]) begin
          e.status = ST_FOUND;
          e.slot   = slot_of[id];
        end else begin
          e.status = ST_ABSENT;
        end
      end
      e.occupancy = OCC_OUT_W'(occupied);
      if (occupied > peak_occupied) peak_occupied = occupied;
      expected_rsp.push_back(e);
    endfunction

    function bit field_ok(string name, int unsigned want, int unsigned got);
      if (want == got) return 1'b1;
      $display("%0t ns: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    endfunction

    // Compare one accepted response beat with the oldest expectation.
    function void check_response(rsp_t got);
      rsp_t e;
      bit   ok;
      if (expected_rsp.size() == 0) begin
        $display("%0t ns: response with nothing expected, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      e  = expected_rsp.pop_front();
      ok = field_ok("status", e.status, got.status);
      ok = field_ok("slot", e.slot, got.slot) && ok;
      ok = field_ok("moved", e.moved, got.moved) && ok;
      ok = field_ok("moved_entity", e.moved_entity, got.moved_entity) && ok;
      ok = field_ok("occupancy", e.occupancy, got.occupancy) && ok;
      if (!ok) errors++;
      if (e.status < 7) status_seen[e.status]++;
      if (e.moved) moves_seen++;
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  slot_map_scoreboard sb;
  bit                 calm;      // set during the stretch with no idling on either side
  bit                 hold_done;
  int unsigned        beats_sent;

  always #6 clk = ~clk;

  sparse_set_slot_map i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  function automatic req_t make_req(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id, logic anim);
    req_t r;
    r.kind           = kind;
    r.entity_id      = id;
    r.has_animations = anim;
    return r;
  endfunction

  // Offer one request beat and hold it until accepted, then note it in the
  // scoreboard. valid is left high so a following beat can go out straight away.
  task automatic send_beat(req_t r);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    beats_sent++;
    // Idle now and then, except in the calm stretch.
    if (!calm && $urandom_range(0, 99) < 34) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Build a random beat. Most remove and lookup ids, and a quarter of add ids,
  // are drawn from the entities in the set so they hit; the rest span the whole space.
  task automatic send_random(int unsigned add_pct, int unsigned rem_pct, int unsigned n);
    req_t        r;
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) r.kind = KIND_ADD;
      else if (roll < add_pct + rem_pct) r.kind = KIND_REMOVE;
      else if (roll < 97) r.kind = KIND_LOOKUP;
      else r.kind = KIND_SPARE;
      if (r.kind == KIND_ADD) begin
        r.entity_id      = ($urandom_range(0, 99) < 25) ? sb.pick_member()
                                                        : ID_W'($urandom_range(0, N_IDS - 1));
        r.has_animations = ($urandom_range(0, 99) < 90);
      end else begin
        r.entity_id      = ($urandom_range(0, 99) < 75) ? sb.pick_member()
                                                        : ID_W'($urandom_range(0, N_IDS - 1));
        r.has_animations = 1'($urandom_range(0, 1));
      end
      send_beat(r);
    end
  endtask

  // Receiver: stall at random, drop the stalls in the calm stretch, and once
  // hold off for a long stretch so the block fills up and blocks its input.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sb != null && sb.checked >= 150) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (calm) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // Check every response beat taken at this edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  initial begin
    #5ms;
    $display("%0t ns: timeout", $time);
    $display("** sparse_set_slot_map: FAILED **");
    $finish;
  end

  initial begin
    sb         = new();
    calm       = 1'b0;
    hold_done  = 1'b0;
    beats_sent = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // The block clears its id map after reset; ready stays low until then.

    // Directed: empty-table misses, refusal, extremes of the id, re-add,
    // refusal of a present entity, spare kind, swap and tail removals.
    send_beat(make_req(KIND_LOOKUP, 10'd5, 1'b1));
    send_beat(make_req(KIND_REMOVE, 10'd5, 1'b0));
    send_beat(make_req(KIND_ADD, 10'd0, 1'b0));
    send_beat(make_req(KIND_ADD, 10'd0, 1'b1));
    send_beat(make_req(KIND_ADD, 10'd1023, 1'b1));
    send_beat(make_req(KIND_ADD, 10'd512, 1'b1));
    send_beat(make_req(KIND_ADD, 10'd0, 1'b1));
    send_beat(make_req(KIND_ADD, 10'd0, 1'b0));
    send_beat(make_req(KIND_LOOKUP, 10'd1023, 1'b0));
    send_beat(make_req(KIND_SPARE, 10'd512, 1'b1));
    send_beat(make_req(KIND_SPARE, 10'd7, 1'b0));
    send_beat(make_req(KIND_REMOVE, 10'd0, 1'b1));
    send_beat(make_req(KIND_LOOKUP, 10'd512, 1'b0));
    send_beat(make_req(KIND_REMOVE, 10'd1023, 1'b0));
    send_beat(make_req(KIND_REMOVE, 10'd1023, 1'b1));
    send_beat(make_req(KIND_REMOVE, 10'd512, 1'b0));
    send_beat(make_req(KIND_LOOKUP, 10'd0, 1'b1));
    send_beat(make_req(KIND_ADD, 10'd341, 1'b1));
    send_beat(make_req(KIND_ADD, 10'd682, 1'b1));

    // Random: fill past capacity, churn while full, calm stretch, drain, mix.
    send_random(75, 10, 420);
    send_random(45, 45, 200);
    calm = 1'b1;
    send_random(40, 40, 150);
    calm = 1'b0;
    send_random(15, 70, 230);
    send_random(40, 35, 100);
    req_valid <= 1'b0;

    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d request beats, checked %0d responses, %0d swap moves, peak occupancy %0d.",
             beats_sent, sb.checked, sb.moves_seen, sb.peak_occupied);
    $display("Statuses: added %0d, present %0d, refused %0d, full %0d,",
             sb.status_seen[ST_ADDED], sb.status_seen[ST_PRESENT], sb.status_seen[ST_REFUSED],
             sb.status_seen[ST_FULL]);
    $display("          removed %0d, absent %0d, found %0d.",
             sb.status_seen[ST_REMOVED], sb.status_seen[ST_ABSENT], sb.status_seen[ST_FOUND]);
    if (sb.errors == 0) begin
      $display("** sparse_set_slot_map: PASSED **");
    end else begin
      $display("** sparse_set_slot_map: FAILED **");
    end
    $finish;
  end

endmodule

>>> sparse_set_slot_map.f
src/ssm_pkg.sv
src/ssm_ram.sv
src/sparse_set_slot_map.sv
verif/sparse_set_slot_map_tb.sv
